FILE: hw/rtl/kpdc_pkg.sv
package kpdc_pkg;

    localparam int KEY_COUNT = 3;
    localparam int MASK_W    = 3;
    localparam int TIME_W    = 32;
    localparam int TH_W      = 16;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;

    // Keys beyond KEY_COUNT are ignored.
    localparam logic [MASK_W-1:0] KEY_BITS = MASK_W'((64'd1 << KEY_COUNT) - 64'd1);

    localparam logic [TH_W-1:0] SHORT_TH_RST    = 16'd50;
    localparam logic [TH_W-1:0] LONG_TH_RST     = 16'd1000;
    localparam logic [TH_W-1:0] CONTINUE_TH_RST = 16'd2000;

    typedef enum logic [1:0] {
        REG_SHORT_TH    = 2'd0,
        REG_LONG_TH     = 2'd1,
        REG_CONTINUE_TH = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        EDGE_NONE     = 2'd0,
        EDGE_HELD     = 2'd1,
        EDGE_RELEASED = 2'd2
    } t_edge;

    typedef enum logic [1:0] {
        LVL_NONE  = 2'd0,
        LVL_SHORT = 2'd1,
        LVL_LONG  = 2'd2,
        LVL_CONT  = 2'd3
    } t_level;

    typedef struct packed {
        logic [MASK_W-1:0] key_mask;
        logic [TIME_W-1:0] now_ms;
    } t_key_in;

    typedef struct packed {
        logic [1:0]        edge_code;
        logic [1:0]        level_code;
        logic [MASK_W-1:0] pressed_keys;
        logic [MASK_W-1:0] released_keys;
    } t_key_out;

endpackage

FILE: hw/rtl/key_press_duration_classifier.sv
// Key press duration classifier: takes one key sample (mask plus a wrapping
// millisecond stamp) per transaction and returns exactly one result
// transaction for it. A new sample is taken in every cycle in which
// o_in_stall is low; the result is registered and appears in the next
// cycle, so it sustains one sample per clock as long as the result side
// drains. The single output register sets that figure: while a result is
// stalled, o_in_stall is raised. A press is timed against the short, long
// and continuous thresholds (APB registers at 0x0, 0x4, 0x8, 16 bits each);
// each level step is reported once, and a release reports the level the
// press had reached. A result with edge code zero carries all-zero fields.
module key_press_duration_classifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  kpdc_pkg::t_key_in            i_in_data,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output kpdc_pkg::t_key_out           o_out_data,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kpdc_pkg::CFG_AW-1:0]  paddr,
    input  logic [kpdc_pkg::CFG_DW-1:0]  pwdata,
    output logic [kpdc_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import kpdc_pkg::*;

    // threshold registers
    logic [TH_W-1:0] r_short_th, r_long_th, r_cont_th;
    t_reg_idx        cfg_idx;
    logic            cfg_wr;

    // tracker state
    logic [MASK_W-1:0] r_last, n_last;
    logic [MASK_W-1:0] r_press, n_press;
    logic [MASK_W-1:0] r_rel, n_rel;
    logic [TIME_W-1:0] r_stamp, n_stamp;
    t_edge             r_edge, n_edge;
    t_level            r_level, n_level;

    // result register
    logic     r_out_valid;
    t_key_out r_out, n_out;

    logic              in_acc;
    logic [MASK_W-1:0] m;
    logic [TIME_W-1:0] elapsed;
    logic [TH_W-1:0]   th;
    logic              reached;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_SHORT_TH:    prdata = CFG_DW'(r_short_th);
            REG_LONG_TH:     prdata = CFG_DW'(r_long_th);
            REG_CONTINUE_TH: prdata = CFG_DW'(r_cont_th);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_th <= SHORT_TH_RST;
            r_long_th  <= LONG_TH_RST;
            r_cont_th  <= CONTINUE_TH_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SHORT_TH:    r_short_th <= pwdata[TH_W-1:0];
                REG_LONG_TH:     r_long_th  <= pwdata[TH_W-1:0];
                REG_CONTINUE_TH: r_cont_th  <= pwdata[TH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Hold the input while a result waits and the far side does not take it.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- classification ----------------
    assign m       = i_in_data.key_mask & KEY_BITS;
    assign elapsed = i_in_data.now_ms - r_stamp;

    always_comb begin
        case (r_level)
            LVL_NONE:  th = r_short_th;
            LVL_SHORT: th = r_long_th;
            default:   th = r_cont_th;
        endcase
    end

    // Negative elapsed time never reaches a threshold.
    assign reached = !elapsed[TIME_W-1] && (elapsed[TIME_W-2:0] >= (TIME_W-1)'(th));

    always_comb begin
        n_last  = r_last;
        n_press = r_press;
        n_rel   = r_rel;
        n_stamp = r_stamp;
        n_edge  = r_edge;
        n_level = r_level;
        n_out   = '0;
        if (m != '0 || r_last != '0) begin
            if (m == r_last) begin
                // step the level once per threshold while held
                if (r_edge == EDGE_HELD && r_level != LVL_CONT && reached) begin
                    n_level             = t_level'(r_level + 2'd1);
                    n_out.edge_code     = EDGE_HELD;
                    n_out.level_code    = n_level;
                    n_out.pressed_keys  = r_press;
                    n_out.released_keys = r_rel;
                end
            end else if ((m & r_last) == r_last) begin
                // new keys only: start a fresh press
                n_press = m;
                n_stamp = i_in_data.now_ms;
                n_rel   = '0;
                n_edge  = EDGE_HELD;
                n_level = LVL_NONE;
                n_last  = m;
            end else if ((m | r_last) == r_last) begin
                // keys lost only: report the release
                n_rel               = r_rel | (r_last & ~m);
                n_edge              = EDGE_RELEASED;
                n_last              = m;
                n_out.edge_code     = EDGE_RELEASED;
                n_out.level_code    = r_level;
                n_out.pressed_keys  = r_press;
                n_out.released_keys = r_rel | (r_last & ~m);
            end else begin
                // keys gained and lost: record both, report nothing
                n_press = m;
                n_stamp = i_in_data.now_ms;
                n_rel   = r_rel | (r_last & ~m);
                n_last  = m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_press     <= '0;
            r_rel       <= '0;
            r_stamp     <= '0;
            r_edge      <= EDGE_NONE;
            r_level     <= LVL_NONE;
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_last      <= n_last;
            r_press     <= n_press;
            r_rel       <= n_rel;
            r_stamp     <= n_stamp;
            r_edge      <= n_edge;
            r_level     <= n_level;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: hw/rtl/kpdc_chk.sv
module kpdc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input kpdc_pkg::t_key_out  o_out_data
);
    import kpdc_pkg::*;

    // every accepted sample yields a result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted sample produced no result");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // silent results carry zero fields
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.edge_code == EDGE_NONE) |->
        (o_out_data.level_code == '0 && o_out_data.pressed_keys == '0
         && o_out_data.released_keys == '0))
        else $error("silent result with nonzero fields");

    // a held report never carries level none
    a_held_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.edge_code == EDGE_HELD) |->
        (o_out_data.level_code != LVL_NONE))
        else $error("held report with level none");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind key_press_duration_classifier kpdc_chk u_kpdc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: test/tb_key_press_duration_classifier.sv
module tb_key_press_duration_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import kpdc_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    logic              smp_valid = 1'b0;
    logic              smp_stall;
    t_key_in           smp_data  = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    t_key_out          res_data;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [CFG_DW-1:0] pwdata  = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    key_press_duration_classifier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (smp_valid),
        .o_in_stall  (smp_stall),
        .i_in_data   (smp_data),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_data  (res_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Run bookkeeping
    // ------------------------------------------------------------------
    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_reports = 0;   // results with a nonzero edge code

    // Percent of samples sent after an idle gap (tx) and of cycles with a result stall (rx).
    int tx_pct = 0;
    int rx_pct = 0;

    // Long result-side hold-off: the test raises the request, the stall
    // process loads and counts it down.
    bit holdoff_req  = 1'b0;
    int holdoff_left = 0;

    // Expected results, oldest first.
    t_key_out pending_reports[$];

    // ------------------------------------------------------------------
    // Predictor: its own copy of thresholds and press-tracking state
    // ------------------------------------------------------------------
    logic [TH_W-1:0]   th_short = SHORT_TH_RST;
    logic [TH_W-1:0]   th_long  = LONG_TH_RST;
    logic [TH_W-1:0]   th_cont  = CONTINUE_TH_RST;

    logic [MASK_W-1:0] prev_keys    = '0;
    logic [MASK_W-1:0] held_keys    = '0;
    logic [MASK_W-1:0] lifted_keys  = '0;
    logic [TIME_W-1:0] press_ms     = '0;
    t_edge             track_edge   = EDGE_NONE;
    t_level            track_level  = LVL_NONE;

    // Classify one sample against the tracked press and advance the state.
    function automatic t_key_out classify_sample(t_key_in s);
        logic [MASK_W-1:0] m;
        logic [TIME_W-1:0] dt;
        logic [TH_W-1:0]   th;
        t_key_out          r;
        m = s.key_mask & KEY_BITS;
        r = '0;
        if (m != '0 || prev_keys != '0) begin
            if (m == prev_keys) begin
                // Same keys: step the level once its threshold is reached.
                if (track_edge == EDGE_HELD && track_level != LVL_CONT) begin
                    case (track_level)
                        LVL_NONE:  th = th_short;
                        LVL_SHORT: th = th_long;
                        default:   th = th_cont;
                    endcase
                    dt = s.now_ms - press_ms;
                    // Wrapped difference read as signed: negative never fires.
                    if ($signed(dt) >= $signed({{(TIME_W-TH_W){1'b0}}, th})) begin
                        track_level  = t_level'(track_level + 2'd1);
                        r.edge_code  = EDGE_HELD;
                        r.level_code = track_level;
                    end
                end
            end else if ((m & prev_keys) == prev_keys) begin
                // Keys added only: start a new press.
                held_keys   = m;
                press_ms    = s.now_ms;
                lifted_keys = '0;
                track_edge  = EDGE_HELD;
                track_level = LVL_NONE;
                prev_keys   = m;
            end else if ((m | prev_keys) == prev_keys) begin
                // Keys lost only: report the release with the reached level.
                lifted_keys  = lifted_keys | (prev_keys & ~m);
                track_edge   = EDGE_RELEASED;
                prev_keys    = m;
                r.edge_code  = EDGE_RELEASED;
                r.level_code = track_level;
            end else begin
                // Gained and lost at once: restamp silently, keep the level.
                held_keys   = m;
                press_ms    = s.now_ms;
                lifted_keys = lifted_keys | (prev_keys & ~m);
                prev_keys   = m;
            end
        end
        if (r.edge_code != EDGE_NONE) begin
            r.pressed_keys  = held_keys;
            r.released_keys = lifted_keys;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall driver and checker
    // ------------------------------------------------------------------
    // Drive the result stall at the rising edge; a pending hold-off wins.
    always @(posedge i_clk) begin
        if (holdoff_req) begin
            holdoff_left = 250;
            holdoff_req  = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // Sample at the falling edge: what is seen here is what the next rising
    // edge takes, so the compare does not race the block's outputs.
    always begin : result_check
        t_key_out want;
        @(negedge i_clk);
        if (i_rst_n && res_valid && !res_stall) begin
            n_checked = n_checked + 1;
            if (pending_reports.size() == 0) begin
                $error("unexpected result transaction: edge_code %0d level_code %0d",
                       res_data.edge_code, res_data.level_code);
                n_errors = n_errors + 1;
            end else begin
                want = pending_reports.pop_front();
                if (want.edge_code != EDGE_NONE) n_reports = n_reports + 1;
                if (res_data.edge_code !== want.edge_code) begin
                    $error("edge_code: expected %0d, got %0d",
                           want.edge_code, res_data.edge_code);
                    n_errors = n_errors + 1;
                end
                if (res_data.level_code !== want.level_code) begin
                    $error("level_code: expected %0d, got %0d",
                           want.level_code, res_data.level_code);
                    n_errors = n_errors + 1;
                end
                if (res_data.pressed_keys !== want.pressed_keys) begin
                    $error("pressed_keys: expected %0d, got %0d",
                           want.pressed_keys, res_data.pressed_keys);
                    n_errors = n_errors + 1;
                end
                if (res_data.released_keys !== want.released_keys) begin
                    $error("released_keys: expected %0d, got %0d",
                           want.released_keys, res_data.released_keys);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------
    // Offer one sample and hold it until the block takes it. Entered and
    // left at a rising edge; valid stays high between back-to-back samples.
    task automatic send_sample(logic [MASK_W-1:0] mask, logic [TIME_W-1:0] stamp);
        t_key_in item;
        bit      taken;
        item.key_mask = mask;
        item.now_ms   = stamp;
        if ($urandom_range(99) < tx_pct) begin
            // Drop valid and scramble the idle payload before offering the sample.
            smp_valid <= 1'b0;
            smp_data  <= {3'($urandom_range(7)), 32'($urandom())};
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        smp_valid <= 1'b1;
        smp_data  <= item;
        do begin
            @(negedge i_clk);
            taken = !smp_stall;
            if (taken) begin
                pending_reports.push_back(classify_sample(item));
                n_sent = n_sent + 1;
            end
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic drain();
        smp_valid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_access(bit wr, t_reg_idx idx, logic [CFG_DW-1:0] wdata,
                              output logic [CFG_DW-1:0] rdata);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done  = pready;
            rdata = prdata;
            @(posedge i_clk);
        end while (!done);
        // Return the bus to idle.
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read one threshold back and compare its low 16 bits.
    task automatic check_threshold(t_reg_idx idx, logic [TH_W-1:0] want);
        logic [CFG_DW-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd[TH_W-1:0] !== want) begin
            $error("threshold register %s: expected %0d, got %0d", idx.name(), want,
                   rd[TH_W-1:0]);
            n_errors = n_errors + 1;
        end
    endtask

    // Write all three thresholds (idle block only) and read them back.
    task automatic set_thresholds(logic [TH_W-1:0] s, logic [TH_W-1:0] l,
                                  logic [TH_W-1:0] c);
        logic [CFG_DW-1:0] rd;
        // Upper data bits carry noise; only the low 16 bits are kept.
        apb_access(1'b1, REG_SHORT_TH,    {16'($urandom()), s}, rd);
        apb_access(1'b1, REG_LONG_TH,     {16'($urandom()), l}, rd);
        apb_access(1'b1, REG_CONTINUE_TH, {16'($urandom()), c}, rd);
        th_short = s;
        th_long  = l;
        th_cont  = c;
        check_threshold(REG_SHORT_TH, s);
        check_threshold(REG_LONG_TH, l);
        check_threshold(REG_CONTINUE_TH, c);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset thresholds, then a walk through every kind of key change.
    task automatic test_directed_cases();
        check_threshold(REG_SHORT_TH, SHORT_TH_RST);
        check_threshold(REG_LONG_TH, LONG_TH_RST);
        check_threshold(REG_CONTINUE_TH, CONTINUE_TH_RST);
        send_sample(3'b000, 32'd0);            // nothing pressed before or now
        send_sample(3'b001, 32'd100);          // press
        send_sample(3'b001, 32'd149);          // one short of the short threshold
        send_sample(3'b001, 32'd150);          // short
        send_sample(3'b001, 32'd150);          // short already reported
        send_sample(3'b001, 32'd1100);         // long
        send_sample(3'b001, 32'd2100);         // continuous
        send_sample(3'b001, 32'd9000);         // continuous stays silent
        send_sample(3'b011, 32'd9001);         // added key restarts the press
        send_sample(3'b110, 32'd9002);         // keys gained and lost together
        send_sample(3'b110, 32'd9052);         // short from the new stamp
        send_sample(3'b100, 32'd9100);         // release with level short
        send_sample(3'b100, 32'd20000);        // same keys while released
        send_sample(3'b000, 32'd20001);        // last key up
        send_sample(3'b000, 32'd5);
        send_sample(3'b111, 32'hFFFF_FFF0);    // all keys, near wrap
        send_sample(3'b111, 32'hFFFF_FF00);    // negative elapsed time
        send_sample(3'b111, 32'h0000_0022);    // wrapped elapsed reaches short
        send_sample(3'b111, 32'hFFFF_FFFF);
        send_sample(3'b111, 32'h7FFF_FFF0);    // most negative difference
        send_sample(3'b101, 32'h7FFF_FFF1);
        send_sample(3'b000, 32'd0);
        send_sample(3'b010, 32'd100);
        send_sample(3'b000, 32'd101);          // release before any level
        send_sample(3'b000, 32'd0);
        drain();
    endtask

    // Thresholds at both ends of their range.
    task automatic test_threshold_extremes();
        set_thresholds(16'd0, 16'd0, 16'd0);
        send_sample(3'b100, 32'd7);
        repeat (4) send_sample(3'b100, 32'd7);   // levels fire on successive samples, the last stays silent
        send_sample(3'b000, 32'd7);
        drain();
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(3'b011, 32'd0);
        send_sample(3'b011, 32'd65534);
        send_sample(3'b011, 32'd65535);
        send_sample(3'b011, 32'd131069);
        send_sample(3'b011, 32'd131070);
        send_sample(3'b011, 32'h7FFF_FFFF);      // largest positive difference
        send_sample(3'b001, 32'h8000_0000);
        send_sample(3'b000, 32'h8000_0001);
        drain();
    endtask

    // Random key sessions: mostly well-formed press, hold and release steps.
    task automatic test_random_sessions(int n, int tx, int rx);
        logic [MASK_W-1:0] mask;
        logic [TIME_W-1:0] ms;
        logic [TH_W-1:0]   top;
        int                r;
        tx_pct = tx;
        rx_pct = rx;
        mask   = '0;
        ms     = $urandom();
        top    = th_short;
        if (th_long > top) top = th_long;
        if (th_cont > top) top = th_cont;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                ms = ms + $urandom_range(0, top / 6 + 1);          // hold
            end else if (r < 65) begin
                mask = mask | 3'($urandom_range(1, 7));            // press more
                ms   = ms + $urandom_range(0, 20);
            end else if (r < 85) begin
                mask = mask & ~3'($urandom_range(1, 7));           // let go
                ms   = ms + $urandom_range(0, 20);
            end else if (r < 92) begin
                mask = 3'($urandom_range(7));                      // swap keys
                ms   = ms + $urandom_range(0, 20);
            end else if (r < 96) begin
                ms = ms + $urandom();                              // clock jump
            end else begin
                mask = 3'($urandom_range(7));                      // noise
                ms   = $urandom();
            end
            send_sample(mask, ms);
        end
        drain();
    endtask

    // Hold the result side off while samples keep coming, so the block
    // fills up and stalls its input.
    task automatic test_result_holdoff();
        logic [TIME_W-1:0] ms;
        tx_pct      = 0;
        rx_pct      = 0;
        ms          = 32'd1000;
        holdoff_req = 1'b1;
        send_sample(3'b001, ms);
        repeat (40) begin
            ms = ms + $urandom_range(0, 40);
            send_sample(($urandom_range(3) == 0) ? 3'b000 : 3'b001, ms);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_threshold_extremes();

        set_thresholds(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 300)));
        test_random_sessions(520, 33, 57);

        set_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
        test_random_sessions(520, 57, 33);

        set_thresholds(16'($urandom_range(0, 80)), 16'($urandom_range(100, 400)),
                       16'($urandom_range(400, 900)));
        test_random_sessions(520, 0, 0);

        test_result_holdoff();

        wait (pending_reports.size() == 0);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d key samples, %0d results checked (%0d level or release reports),",
                 n_sent, n_checked, n_reports);
        $display("over thresholds from 0 to 65535, mixed idle and stall, and a long hold-off.");
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Give up on a hung handshake.
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/kpdc_pkg.sv
hw/rtl/key_press_duration_classifier.sv
hw/rtl/kpdc_chk.sv
test/tb_key_press_duration_classifier.sv
